// ===== hw/rtl/rfb_pkg.sv =====
// Shared types and constants for the rectangle fill engine.
// No dependencies.
`timescale 1ns / 1ps

package rfb_pkg;

  localparam int CMD_W     = 2;
  localparam int COORD_W   = 8;
  localparam int SIZE_W    = 9;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int AREA_W    = 2 * SIZE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } reg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic prep;
    logic clr_step;
    logic fill_step;
    logic rd_issue;
    logic rd_capture;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic limit_zero;
    logic fill_empty;
    logic rd_oob;
    logic clr_last;
    logic fill_last;
  } status_t;

endpackage

// ===== hw/rtl/rfb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rfb_datapath.sv =====
// Datapath: config registers, index arithmetic, loop counters, result regs.
// Depends on rfb_pkg.
`timescale 1ns / 1ps

module rfb_datapath #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int IW    = 19
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [rfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rfb_pkg::SIZE_W-1:0]     cfg_data_i,
  input  rfb_pkg::ctrl_t                 ctrl_i,
  output rfb_pkg::status_t               status_o,
  input  logic [rfb_pkg::CMD_W-1:0]      cmd_i,
  input  logic [rfb_pkg::COORD_W-1:0]    rect_x_i,
  input  logic [rfb_pkg::COORD_W-1:0]    rect_y_i,
  input  logic [rfb_pkg::SIZE_W-1:0]     rect_w_i,
  input  logic [rfb_pkg::SIZE_W-1:0]     rect_h_i,
  input  logic [rfb_pkg::COLOR_W-1:0]    fill_color_i,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [rfb_pkg::COLOR_W-1:0]    mem_wdata_o,
  output logic                           mem_re_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [rfb_pkg::COLOR_W-1:0]    mem_rdata_i,
  output logic [rfb_pkg::COLOR_W-1:0]    pixel_color_o,
  output logic                           out_of_range_o
);

  import rfb_pkg::*;

  localparam logic [IW-1:0] DEPTH_IW = IW'(DEPTH);

  logic [SIZE_W-1:0]  sw_q, sh_q;
  cmd_e               cmd_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [SIZE_W-1:0]  w_q, h_q;
  logic [COLOR_W-1:0] color_q;
  logic [AREA_W-1:0]  area_q, prod_q;
  logic [IW-1:0]      limit_q, idx_q, row_base_q;
  logic [SIZE_W-1:0]  col_q, row_q;
  logic               rd_oob_q;
  logic               flag_q;
  logic [COLOR_W-1:0] pixel_q;

  logic [IW-1:0] start_idx;
  logic [IW-1:0] next_row;
  logic          idx_in;
  logic          area_over;
  logic          col_last;

  assign start_idx = IW'(prod_q) + IW'(x_q);
  assign next_row  = row_base_q + IW'(sw_q);
  assign idx_in    = idx_q < limit_q;
  assign area_over = IW'(area_q) > DEPTH_IW;
  assign col_last  = col_q == w_q - SIZE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= SIZE_W'(256);
      sh_q <= SIZE_W'(256);
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SCREEN_WIDTH:  sw_q <= cfg_data_i;
        REG_SCREEN_HEIGHT: sh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= CMD_CLEAR;
    end else if (ctrl_i.load) begin
      cmd_q <= cmd_e'(cmd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q     <= rect_x_i;
      y_q     <= rect_y_i;
      w_q     <= rect_w_i;
      h_q     <= rect_h_i;
      color_q <= fill_color_i;
      flag_q  <= 1'b0;
      pixel_q <= '0;
    end
    if (ctrl_i.mul) begin
      area_q <= AREA_W'(sw_q) * AREA_W'(sh_q);
      prod_q <= AREA_W'(y_q) * AREA_W'(sw_q);
    end
    if (ctrl_i.prep) begin
      limit_q    <= area_over ? DEPTH_IW : IW'(area_q);
      row_base_q <= start_idx;
      idx_q      <= (cmd_q == CMD_CLEAR) ? '0 : start_idx;
      col_q      <= '0;
      row_q      <= '0;
      rd_oob_q   <= ({1'b0, x_q} >= sw_q) || ({1'b0, y_q} >= sh_q) ||
                    (start_idx >= DEPTH_IW);
      if (cmd_q == CMD_CLEAR && area_over) begin
        flag_q <= 1'b1;
      end
      if (cmd_q == CMD_READ && (({1'b0, x_q} >= sw_q) || ({1'b0, y_q} >= sh_q) ||
                                (start_idx >= DEPTH_IW))) begin
        flag_q <= 1'b1;
      end
    end
    if (ctrl_i.clr_step) begin
      idx_q <= idx_q + IW'(1);
    end
    if (ctrl_i.fill_step) begin
      if (!idx_in) begin
        flag_q <= 1'b1;
      end
      if (col_last) begin
        col_q      <= '0;
        row_q      <= row_q + SIZE_W'(1);
        row_base_q <= next_row;
        idx_q      <= next_row;
      end else begin
        col_q <= col_q + SIZE_W'(1);
        idx_q <= idx_q + IW'(1);
      end
    end
    if (ctrl_i.rd_capture) begin
      pixel_q <= mem_rdata_i;
    end
  end

  assign status_o.cmd        = cmd_q;
  assign status_o.limit_zero = limit_q == '0;
  assign status_o.fill_empty = (w_q == '0) || (h_q == '0);
  assign status_o.rd_oob     = rd_oob_q;
  assign status_o.clr_last   = idx_q == limit_q - IW'(1);
  assign status_o.fill_last  = col_last && (row_q == h_q - SIZE_W'(1));

  assign mem_we_o    = ctrl_i.clr_step || (ctrl_i.fill_step && idx_in);
  assign mem_waddr_o = idx_q[AW-1:0];
  assign mem_wdata_o = ctrl_i.clr_step ? '0 : color_q;
  assign mem_re_o    = ctrl_i.rd_issue;
  assign mem_raddr_o = idx_q[AW-1:0];

  assign pixel_color_o  = pixel_q;
  assign out_of_range_o = flag_q;

endmodule

// ===== hw/rtl/rfb_ctrl.sv =====
// Controller state machine: sequences setup, clear/fill loops and reads.
// Depends on rfb_pkg.
`timescale 1ns / 1ps

module rfb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  output rfb_pkg::ctrl_t   ctrl_o,
  input  rfb_pkg::status_t status_i
);

  import rfb_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_PREP  = 9'b000000100,
    ST_DISP  = 9'b000001000,
    ST_CLEAR = 9'b000010000,
    ST_FILL  = 9'b000100000,
    ST_RD    = 9'b001000000,
    ST_RDW   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = ST_MUL;
      ST_MUL:   state_d = ST_PREP;
      ST_PREP:  state_d = ST_DISP;
      ST_DISP: begin
        case (status_i.cmd)
          CMD_CLEAR: state_d = status_i.limit_zero ? ST_DONE : ST_CLEAR;
          CMD_FILL:  state_d = status_i.fill_empty ? ST_DONE : ST_FILL;
          CMD_READ:  state_d = status_i.rd_oob ? ST_DONE : ST_RD;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_CLEAR: if (status_i.clr_last) state_d = ST_DONE;
      ST_FILL:  if (status_i.fill_last) state_d = ST_DONE;
      ST_RD:    state_d = ST_RDW;
      ST_RDW:   state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o.load       = (state_q == ST_IDLE) && start;
  assign ctrl_o.mul        = state_q == ST_MUL;
  assign ctrl_o.prep       = state_q == ST_PREP;
  assign ctrl_o.clr_step   = state_q == ST_CLEAR;
  assign ctrl_o.fill_step  = state_q == ST_FILL;
  assign ctrl_o.rd_issue   = state_q == ST_RD;
  assign ctrl_o.rd_capture = state_q == ST_RDW;

  assign busy   = state_q != ST_IDLE;
  assign done_o = state_q == ST_DONE;

endmodule

// ===== hw/rtl/rect_fill_framebuffer_engine.sv =====
// Top level of the rectangle fill engine: controller, datapath, framebuffer RAM.
// Depends on rfb_pkg, rfb_ctrl, rfb_datapath, rfb_ram.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; its single result
// appears on pixel_color_o / out_of_range_o for exactly one cycle with
// done_o high, and the receiver cannot stall it. The framebuffer RAM takes
// one write per cycle; a clear writes min(screen_width*screen_height,
// MAX_WIDTH*MAX_HEIGHT) words, a fill steps through rect_w*rect_h pixels,
// a read passes through ST_RD and ST_RDW, and a flagged read or an unknown
// command goes straight to ST_DONE; busy stays high until the result beat.
// Clear the framebuffer before reading it.
// Config writes are always ready and must only be issued while idle.
module rect_fill_framebuffer_engine #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [rfb_pkg::CMD_W-1:0]      cmd_i,
  input  logic [rfb_pkg::COORD_W-1:0]    rect_x_i,
  input  logic [rfb_pkg::COORD_W-1:0]    rect_y_i,
  input  logic [rfb_pkg::SIZE_W-1:0]     rect_w_i,
  input  logic [rfb_pkg::SIZE_W-1:0]     rect_h_i,
  input  logic [rfb_pkg::COLOR_W-1:0]    fill_color_i,
  output logic                           done_o,
  output logic [rfb_pkg::COLOR_W-1:0]    pixel_color_o,
  output logic                           out_of_range_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rfb_pkg::SIZE_W-1:0]     cfg_data_i
);

  import rfb_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (AW + 1 > AREA_W + 1) ? AW + 1 : AREA_W + 1;

  ctrl_t              ctrl;
  status_t            status;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [COLOR_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  rfb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .ctrl_o   (ctrl),
    .status_i (status)
  );

  rfb_datapath #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .IW    (IW)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .cmd_i          (cmd_i),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_w_i       (rect_w_i),
    .rect_h_i       (rect_h_i),
    .fill_color_i   (fill_color_i),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .pixel_color_o  (pixel_color_o),
    .out_of_range_o (out_of_range_o)
  );

  rfb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_fb (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy after result beat");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted command not in progress");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !mem_we)
    else $error("framebuffer write while idle");

  a_flag_zero_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (pixel_color_o == '0))
    else $error("flagged result carries pixel data");

endmodule
